>>> rtl/core/assert_macros.svh
// Assertion macros shared by the median filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MF_ASSERT_NOW(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define MF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/mf_pkg.sv
// Shared types and constants of the 1D median filter.
// No dependencies; used by mf_cell, mf_ctrl and median_filter_1d.
`timescale 1ns / 1ps
`default_nettype none

package mf_pkg;

	localparam int WINDOW = 5;
	localparam int EDGE   = WINDOW / 2;
	localparam int DEPTH  = 2 * EDGE;
	localparam int CELLS  = DEPTH + 1;
	localparam int MED    = WINDOW / 2;

	localparam int SW    = 12;
	localparam int IDX_W = $clog2(CELLS);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int D_W   = $clog2(EDGE + 1);

	typedef logic signed [SW-1:0] sample_t;
	typedef logic [CELLS-1:0][SW-1:0] window_t;
	typedef logic [IDX_W-1:0] idx_t;

endpackage

`default_nettype wire

>>> rtl/core/mf_cell.sv
// One window cell: holds a sample, shifts toward the older end, ranks itself.
// Depends on mf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mf_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire mf_pkg::sample_t   din,
	input  wire mf_pkg::idx_t      pos,
	input  wire mf_pkg::window_t   win,
	output mf_pkg::sample_t        value,
	output logic                   is_med
);

	mf_pkg::sample_t value_q;
	mf_pkg::idx_t    rank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift) begin
			value_q <= din;
		end
	end

	// rank = smaller values plus equal values at older positions (stable order)
	always_comb begin
		rank = '0;
		for (int j = 0; j < mf_pkg::CELLS; j++) begin
			if (mf_pkg::IDX_W'(j) != pos) begin
				if ($signed(win[j]) < $signed(value_q)) begin
					rank = rank + 1'b1;
				end else if (($signed(win[j]) == $signed(value_q))
						&& (mf_pkg::IDX_W'(j) < pos)) begin
					rank = rank + 1'b1;
				end
			end
		end
	end

	assign value  = value_q;
	assign is_med = (rank == mf_pkg::IDX_W'(mf_pkg::MED));

endmodule

`default_nettype wire

>>> rtl/core/mf_ctrl.sv
// Item sequencing, block position count and output register of the filter.
// Depends on mf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic              block_end,
	output logic                   shift,
	input  wire mf_pkg::window_t   win,
	input  wire mf_pkg::sample_t   median,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output mf_pkg::sample_t        filtered,
	output logic                   last_out
);

	logic                     seen_q;
	logic [mf_pkg::CNT_W-1:0] seen_cnt_q;
	logic                     valid_s1;
	logic                     last_s1;
	logic [mf_pkg::CNT_W-1:0] pos_s1;
	logic [mf_pkg::D_W-1:0]   d_s1;
	logic                     out_valid_q;
	mf_pkg::sample_t          filtered_q;
	logic                     last_q;

	logic                     emit;
	logic                     out_free;
	logic                     adv;
	logic                     done;
	logic                     use_med;
	mf_pkg::sample_t          raw;
	logic [mf_pkg::D_W-1:0]   d_start;

	assign seen_q = (seen_cnt_q >= mf_pkg::CNT_W'(mf_pkg::EDGE));

	always_comb begin
		emit       = valid_s1 && (last_s1 || (pos_s1 >= mf_pkg::CNT_W'(mf_pkg::EDGE)));
		out_free   = !out_valid_q || result_ready;
		adv        = valid_s1 && (!emit || out_free);
		done       = adv && (!last_s1 || (d_s1 == '0));
		item_ready = !valid_s1 || done;
		shift      = item_valid && item_ready;
		use_med    = (d_s1 == mf_pkg::D_W'(mf_pkg::EDGE))
			&& (pos_s1 == mf_pkg::CNT_W'(mf_pkg::DEPTH));
		raw        = win[mf_pkg::IDX_W'(mf_pkg::DEPTH) - mf_pkg::IDX_W'(d_s1)];
		// end of block flushes min(pos, EDGE)+1 results, oldest first
		if (block_end && !seen_q) begin
			d_start = mf_pkg::D_W'(seen_cnt_q);
		end else begin
			d_start = mf_pkg::D_W'(mf_pkg::EDGE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cnt_q <= '0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			pos_s1     <= '0;
			d_s1       <= '0;
		end else if (shift) begin
			valid_s1 <= 1'b1;
			last_s1  <= block_end;
			pos_s1   <= seen_cnt_q;
			d_s1     <= d_start;
			if (block_end) begin
				seen_cnt_q <= '0;
			end else if (seen_cnt_q < mf_pkg::CNT_W'(mf_pkg::DEPTH)) begin
				seen_cnt_q <= seen_cnt_q + 1'b1;
			end
		end else if (done) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			d_s1 <= d_s1 - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			filtered_q <= use_med ? median : raw;
			last_q     <= last_s1 && (d_s1 == '0);
		end
	end

	assign result_valid = out_valid_q;
	assign filtered     = filtered_q;
	assign last_out     = last_q;

endmodule

`default_nettype wire

>>> rtl/core/median_filter_1d.sv
// Streaming 1D median filter, window of five samples, top level.
// Depends on mf_pkg, mf_cell, mf_ctrl and assert_macros.svh.
//
// Usage:
//  Input channel item_valid/item_ready carries sample (12-bit signed,
//  1/16 degC) and block_end. Output channel result_valid/result_ready
//  carries filtered and last_out. A beat moves when valid and ready are high.
//  Sample j is reported when sample j+2 arrives: median of samples j-2..j+2,
//  raw for the first two and the last two samples of a block. The block_end
//  beat flushes up to three results, the final one with last_out set.
//  Each result passes through the control stage and then the output register.
//  Throughput: one beat per cycle while item_ready is high; a block_end beat
//  occupies the control stage until all of its results (up to three) have left,
//  since all of them are read from the one window held in the cell row.
//  A result waiting in the output register does not block the next beat
//  unless a new result needs that register; with result_ready low the
//  output holds and item_ready drops once the stage has a result pending.
//  Reset (arst_n low) clears the window to zero, the block count and all
//  valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module median_filter_1d (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire logic signed [11:0]   sample,
	input  wire logic                 block_end,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic signed [11:0]        filtered,
	output logic                      last_out
);

	// window row: cell 0 oldest, cell DEPTH newest
	mf_pkg::window_t           win;
	logic [mf_pkg::CELLS-1:0]  med_sel;
	mf_pkg::sample_t           median;
	logic                      shift;

	for (genvar k = 0; k < mf_pkg::CELLS; k++) begin : g_cell
		mf_pkg::sample_t din;
		mf_pkg::sample_t value;

		if (k == mf_pkg::DEPTH) begin : g_head
			assign din = sample;
		end else begin : g_link
			assign din = mf_pkg::sample_t'(win[k+1]);
		end

		mf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.din    (din),
			.pos    (mf_pkg::IDX_W'(k)),
			.win    (win),
			.value  (value),
			.is_med (med_sel[k])
		);

		assign win[k] = value;
	end

	// exactly one cell carries the median rank; pick it out
	always_comb begin
		median = '0;
		for (int k = 0; k < mf_pkg::CELLS; k++) begin
			if (med_sel[k]) begin
				median = median | mf_pkg::sample_t'(win[k]);
			end
		end
	end

	mf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.block_end    (block_end),
		.shift        (shift),
		.win          (win),
		.median       (median),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.filtered     (filtered),
		.last_out     (last_out)
	);

	// ranks form a permutation, so one median cell only
	`MF_ASSERT_NOW(a_med_onehot, clk, arst_n, $onehot(med_sel))
	// an accepted beat lands in the newest cell and pushes the row along
	`MF_ASSERT_NEXT(a_shift_in, clk, arst_n, item_valid && item_ready,
		(win[mf_pkg::DEPTH] == $past(sample))
		&& (win[mf_pkg::DEPTH-1] == $past(win[mf_pkg::DEPTH])))
	// without an accepted beat the window holds
	`MF_ASSERT_NEXT(a_hold, clk, arst_n, !(item_valid && item_ready), $stable(win))

endmodule

`default_nettype wire

>>> tb/sv/median_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the 1D median filter: predicts filtered beats, checks them.
// Depends on mf_pkg for the sample type and window constants.

package median_check_pkg;

	import mf_pkg::*;

	typedef struct {
		sample_t value;
		bit      last;
	} filtered_beat_t;

	class median_tracker;
		sample_t        history[DEPTH];  // previous samples, oldest first
		int unsigned    seen;            // samples seen in block, saturates at DEPTH
		filtered_beat_t owed[$];         // filtered beats not yet returned
		int unsigned    mismatches;

		function new();
			foreach (history[i]) history[i] = '0;
			seen = 0;
			mismatches = 0;
		endfunction

		function sample_t median_of_span(sample_t span[DEPTH+1]);
			sample_t w[DEPTH+1];
			sample_t tmp;
			w = span;
			for (int i = 0; i < DEPTH; i++) begin
				for (int k = 0; k < DEPTH - i; k++) begin
					if (w[k] > w[k+1]) begin
						tmp = w[k];
						w[k] = w[k+1];
						w[k+1] = tmp;
					end
				end
			end
			return w[WINDOW/2];
		endfunction

		function void note_sample(sample_t s, bit blk_end);
			sample_t        span[DEPTH+1];
			int             a;
			int             d;
			filtered_beat_t r;
			a = seen;
			foreach (history[i]) span[i] = history[i];
			span[DEPTH] = s;
			if (blk_end) begin
				// flush: oldest pending first, only the one at EDGE back may get a median
				d = (a < EDGE) ? a : EDGE;
				while (d >= 0) begin
					r.value = (d == EDGE && a >= DEPTH) ? median_of_span(span) : span[DEPTH-d];
					r.last = (d == 0);
					owed.push_back(r);
					d--;
				end
			end else if (a >= EDGE) begin
				r.value = (a >= DEPTH) ? median_of_span(span) : span[DEPTH-EDGE];
				r.last = 1'b0;
				owed.push_back(r);
			end
			for (int i = 0; i < DEPTH; i++) history[i] = span[i+1];
			if (blk_end)
				seen = 0;
			else if (seen < DEPTH)
				seen++;
		endfunction

		function int unsigned owed_count();
			return owed.size();
		endfunction

		function void check_filtered(sample_t got, logic got_last);
			filtered_beat_t want;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: filtered=%0d last_out=%b", got, got_last);
				return;
			end
			want = owed.pop_front();
			if (got !== want.value || got_last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: filtered exp %0d got %0d, last_out exp %b got %b",
						want.value, got, want.last, got_last);
			end
		endfunction
	endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top-level bench for median_filter_1d: directed and random sample blocks.
// Depends on mf_pkg, median_check_pkg and the median_filter_1d RTL.

module testbench;

	import mf_pkg::*;
	import median_check_pkg::*;

	// how sample values are drawn for a block
	typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_RAILS} spread_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	sample_t sample;
	logic    block_end;
	logic    result_valid;
	logic    result_ready;
	sample_t filtered;
	logic    last_out;

	median_tracker tracker = new();

	int unsigned beats_sent = 0;
	bit          quiet_tail = 1'b0;  // no idling on either side once set
	int unsigned stall_left = 0;
	int unsigned stall_odds = 10;
	int unsigned tick = 0;

	// directed blocks of length 1..6: rails, sign changes, ties
	int dir_lens[6]     = '{1, 2, 3, 4, 5, 6};
	int dir_samples[21] = '{2047,
	                        -2048, 2047,
	                        0, -1, 1,
	                        2047, -2048, 2047, -2048,
	                        -2048, 2047, -2048, 2047, 0,
	                        5, 5, 5, -5, -5, -5};

	median_filter_1d dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.sample       (sample),
		.block_end    (block_end),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.filtered     (filtered),
		.last_out     (last_out)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Monitor: both channels sampled at the rising edge. Results are checked
	// before the new input is noted; a result always stems from an earlier beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				tracker.check_filtered(filtered, last_out);
			if (item_valid && item_ready)
				tracker.note_sample(sample, block_end);
		end
	end

	// Receiver backpressure: stall bursts of random length; the stall rate is
	// re-rolled among 0, 8 and 25 percent, a zero rate gives calm stretches.
	always @(negedge clk) begin
		if (quiet_tail) begin
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < stall_odds) begin
			result_ready <= 1'b0;
			stall_left = $urandom_range(1, 16) - 1;
		end else begin
			result_ready <= 1'b1;
		end
		tick++;
		if (tick % 80 == 0)
			case ($urandom_range(0, 2))
				0: stall_odds = 0;
				1: stall_odds = 8;
				default: stall_odds = 25;
			endcase
	end

	function automatic sample_t pick_sample(spread_t spread);
		int rails[7] = '{-2048, -2047, -1, 0, 1, 2046, 2047};
		case (spread)
			SPREAD_NARROW: return sample_t'(int'($urandom_range(0, 6)) - 3);
			SPREAD_RAILS:  return sample_t'(rails[$urandom_range(0, 6)]);
			default:       return sample_t'($urandom_range(0, 4095));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the next beat can follow back to back.
	task automatic send_beat(sample_t s, bit e, int unsigned gap_odds);
		if (!quiet_tail && $urandom_range(0, 99) < gap_odds) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		item_valid <= 1'b1;
		sample     <= s;
		block_end  <= e;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_block(int len, spread_t spread);
		int unsigned gap_odds;
		case ($urandom_range(0, 2))
			0: gap_odds = 0;
			1: gap_odds = 15;
			default: gap_odds = 40;
		endcase
		for (int k = 0; k < len; k++)
			send_beat(pick_sample(spread), k == len - 1, gap_odds);
	endtask

	// sender holds off until every owed beat has come back
	task automatic drain();
		item_valid <= 1'b0;
		while (tracker.owed_count() != 0) @(negedge clk);
	endtask

	initial begin
		int      pos;
		int      len;
		int      r;
		bit      mid_pause_done;
		spread_t spread;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		sample       = '0;
		block_end    = 1'b0;
		result_ready = 1'b0;
		pos            = 0;
		mid_pause_done = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: short blocks (all raw), first median at length 5, ties
		foreach (dir_lens[b]) begin
			for (int k = 0; k < dir_lens[b]; k++) begin
				send_beat(sample_t'(dir_samples[pos]), k == dir_lens[b] - 1, 20);
				pos++;
			end
		end
		drain();

		// random blocks: mostly long enough for medians, some short ones
		while (beats_sent < 410) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(5, 14);
			else if (r < 90)
				len = $urandom_range(1, 4);
			else
				len = $urandom_range(20, 40);
			case ($urandom_range(0, 3))
				0: spread = SPREAD_NARROW;
				1: spread = SPREAD_RAILS;
				default: spread = SPREAD_FULL;
			endcase
			if (beats_sent >= 350)
				quiet_tail = 1'b1;
			send_block(len, spread);
			if (!mid_pause_done && beats_sent >= 200) begin
				drain();
				mid_pause_done = 1'b1;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.owed_count() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// run limit: far above the slowest legal run
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mf_pkg.sv
rtl/core/mf_cell.sv
rtl/core/mf_ctrl.sv
rtl/core/median_filter_1d.sv
tb/sv/median_check_pkg.sv
tb/sv/testbench.sv
